// ----- hw/rtl/itff_pkg.sv -----
// ----------------------------------------------------------------------------
// itff_pkg : shared types and constants for the first-frame parser
// Status codes, header constants and the request record passed from the
// decode front end to the result back end.
// ----------------------------------------------------------------------------
`default_nettype none

package itff_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 32;
  localparam int unsigned CountW  = 7;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned QDepth  = 2;

  localparam logic [LenW-1:0] MAX_MESSAGE_LEN = 32'hffff_ffff;
  localparam logic [LenW-1:0] BUF_SIZE_RESET  = 32'd4095;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_EXT_ADDR = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FD_MODE  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BUF_SIZE = 2'd2;

  // status codes
  localparam logic [StatusW-1:0] ST_OK        = 3'd0;
  localparam logic [StatusW-1:0] ST_NOT_FF    = 3'd1;
  localparam logic [StatusW-1:0] ST_BELOW_MIN = 3'd2;
  localparam logic [StatusW-1:0] ST_OVERFLOW  = 3'd3;
  localparam logic [StatusW-1:0] ST_BAD_SIZE  = 3'd4;
  localparam logic [StatusW-1:0] ST_TRUNC     = 3'd5;

  // PCI decode
  localparam logic [ByteW-1:0] PCI_TYPE_MASK = 8'hf0;
  localparam logic [ByteW-1:0] PCI_TYPE_FF   = 8'h10;
  localparam logic [ByteW-1:0] PCI_LEN_MASK  = 8'h0f;

  localparam logic [5:0]        MIN_LEN_CAN = 6'd8;
  localparam logic [5:0]        MIN_LEN_FD  = 6'd63;
  localparam logic [CountW-1:0] MAX_COPY    = 7'd64;

  // one request: an optional payload byte and an optional status result
  typedef struct packed {
    logic               pl_valid;
    logic [ByteW-1:0]   pl_byte;
    logic               st_valid;
    logic [StatusW-1:0] status;
    logic [ByteW-1:0]   ext_address;
    logic [LenW-1:0]    message_length;
    logic [CountW-1:0]  bytes_copied;
    logic [LenW-1:0]    bytes_remaining;
  } itff_req_t;

endpackage

`default_nettype wire

// ----- hw/rtl/itff_front.sv -----
// ----------------------------------------------------------------------------
// itff_front : header decode and frame state
// Takes one frame byte per cycle unless the queue is full, walks the PCI /
// length header, and turns each byte into at most one back-end request.
// ----------------------------------------------------------------------------
`default_nettype none

module itff_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [itff_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [itff_pkg::CfgW-1:0]     cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [itff_pkg::ByteW-1:0]    in_frame_byte,
  input  wire logic                          in_frame_end,
  input  wire logic                          q_full,
  output logic                               q_wr_en,
  output itff_pkg::itff_req_t                q_wr_data
);

  typedef enum logic [2:0] {
    PH_START, PH_PCI, PH_LEN_LO, PH_ESC, PH_DATA, PH_DROP
  } phase_t;

  phase_t                           phase_r, phase_nxt, phase_mid;
  logic [2:0]                       hdr_idx_r, hdr_idx_nxt, hdr_idx_mid;
  logic [itff_pkg::LenW-1:0]        len_r, len_nxt, len_mid;
  logic [itff_pkg::ByteW-1:0]       ext_r, ext_nxt, ext_mid;
  logic [itff_pkg::StatusW-1:0]     err_r, err_nxt, err_mid;
  logic [itff_pkg::CountW-1:0]      copy_r, copy_nxt, copy_mid;

  logic                             ext_en_r;
  logic                             fd_mode_r;
  logic [itff_pkg::LenW-1:0]        buf_size_r;

  logic                             fire;
  logic [itff_pkg::LenW-1:0]        len_cand;
  logic [5:0]                       min_len;
  logic                             check_en;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign min_len  = (fd_mode_r ? itff_pkg::MIN_LEN_FD : itff_pkg::MIN_LEN_CAN)
                    - {5'd0, ext_en_r};

  always_comb begin
    phase_mid   = phase_r;
    hdr_idx_mid = hdr_idx_r;
    len_mid     = len_r;
    ext_mid     = ext_r;
    err_mid     = err_r;
    copy_mid    = copy_r;
    len_cand    = len_r;
    check_en    = 1'b0;
    q_wr_data   = '0;

    case (phase_r)
      PH_START: begin
        ext_mid = '0;
        if (buf_size_r > itff_pkg::MAX_MESSAGE_LEN) begin
          err_mid   = itff_pkg::ST_BAD_SIZE;
          phase_mid = PH_DROP;
        end else if (ext_en_r) begin
          ext_mid   = in_frame_byte;
          phase_mid = PH_PCI;
        end else if ((in_frame_byte & itff_pkg::PCI_TYPE_MASK) != itff_pkg::PCI_TYPE_FF) begin
          err_mid   = itff_pkg::ST_NOT_FF;
          phase_mid = PH_DROP;
        end else begin
          len_mid   = {20'd0, in_frame_byte[3:0] & itff_pkg::PCI_LEN_MASK[3:0], 8'd0};
          phase_mid = PH_LEN_LO;
        end
      end
      PH_PCI: begin
        if ((in_frame_byte & itff_pkg::PCI_TYPE_MASK) != itff_pkg::PCI_TYPE_FF) begin
          err_mid   = itff_pkg::ST_NOT_FF;
          phase_mid = PH_DROP;
        end else begin
          len_mid   = {20'd0, in_frame_byte[3:0] & itff_pkg::PCI_LEN_MASK[3:0], 8'd0};
          phase_mid = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        len_cand = len_r | {24'd0, in_frame_byte};
        len_mid  = len_cand;
        if (len_cand == '0) begin
          hdr_idx_mid = '0;
          phase_mid   = PH_ESC;
        end else begin
          check_en = 1'b1;
        end
      end
      PH_ESC: begin
        len_cand    = {len_r[23:0], in_frame_byte};
        len_mid     = len_cand;
        hdr_idx_mid = hdr_idx_r + 3'd1;
        check_en    = hdr_idx_mid[2];
      end
      PH_DATA: begin
        if (({25'd0, copy_r} < len_r) && (copy_r < itff_pkg::MAX_COPY)) begin
          q_wr_data.pl_valid = 1'b1;
          q_wr_data.pl_byte  = in_frame_byte;
          copy_mid           = copy_r + 7'd1;
        end
      end
      default: begin
      end
    endcase

    // length checks against minimum and buffer capacity
    if (check_en) begin
      if (len_cand < {26'd0, min_len}) begin
        err_mid   = itff_pkg::ST_BELOW_MIN;
        phase_mid = PH_DROP;
      end else if (len_cand > buf_size_r) begin
        err_mid   = itff_pkg::ST_OVERFLOW;
        phase_mid = PH_DROP;
      end else begin
        copy_mid  = '0;
        phase_mid = PH_DATA;
      end
    end

    // end of frame: status request, then clear the frame state
    if (in_frame_end) begin
      q_wr_data.st_valid    = 1'b1;
      q_wr_data.ext_address = ext_mid;
      if (phase_mid == PH_DATA) begin
        q_wr_data.status          = itff_pkg::ST_OK;
        q_wr_data.message_length  = len_mid;
        q_wr_data.bytes_copied    = copy_mid;
        q_wr_data.bytes_remaining = len_mid - {25'd0, copy_mid};
      end else if (phase_mid == PH_DROP) begin
        q_wr_data.status = err_mid;
        if (err_mid == itff_pkg::ST_BELOW_MIN || err_mid == itff_pkg::ST_OVERFLOW) begin
          q_wr_data.message_length = len_mid;
        end
      end else begin
        q_wr_data.status = itff_pkg::ST_TRUNC;
      end
    end

    if (in_frame_end) begin
      phase_nxt   = PH_START;
      hdr_idx_nxt = '0;
      len_nxt     = '0;
      ext_nxt     = '0;
      err_nxt     = '0;
      copy_nxt    = '0;
    end else begin
      phase_nxt   = phase_mid;
      hdr_idx_nxt = hdr_idx_mid;
      len_nxt     = len_mid;
      ext_nxt     = ext_mid;
      err_nxt     = err_mid;
      copy_nxt    = copy_mid;
    end
  end

  assign q_wr_en = fire && (q_wr_data.pl_valid || q_wr_data.st_valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_START;
      hdr_idx_r  <= '0;
      len_r      <= '0;
      ext_r      <= '0;
      err_r      <= '0;
      copy_r     <= '0;
      ext_en_r   <= 1'b0;
      fd_mode_r  <= 1'b0;
      buf_size_r <= itff_pkg::BUF_SIZE_RESET;
    end else begin
      if (fire) begin
        phase_r   <= phase_nxt;
        hdr_idx_r <= hdr_idx_nxt;
        len_r     <= len_nxt;
        ext_r     <= ext_nxt;
        err_r     <= err_nxt;
        copy_r    <= copy_nxt;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          itff_pkg::CFG_EXT_ADDR: ext_en_r   <= cfg_wdata[0];
          itff_pkg::CFG_FD_MODE:  fd_mode_r  <= cfg_wdata[0];
          itff_pkg::CFG_BUF_SIZE: buf_size_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/itff_queue.sv -----
// ----------------------------------------------------------------------------
// itff_queue : two-entry request queue
// Decouples header decode from result delivery.
// ----------------------------------------------------------------------------
`default_nettype none

module itff_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                wr_en,
  input  wire itff_pkg::itff_req_t wr_data,
  output logic                     full,
  output logic                     rd_valid,
  output itff_pkg::itff_req_t      rd_data,
  input  wire logic                rd_pop
);

  localparam int unsigned PtrW = $clog2(itff_pkg::QDepth);
  localparam int unsigned CntW = $clog2(itff_pkg::QDepth + 1);

  itff_pkg::itff_req_t mem_r [itff_pkg::QDepth];
  logic [PtrW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]     count_r, count_nxt;

  assign full     = (count_r == CntW'(itff_pkg::QDepth));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (wr_en && !(rd_pop && rd_valid)) begin
      count_nxt = count_r + CntW'(1);
    end else if (!wr_en && rd_pop && rd_valid) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(itff_pkg::QDepth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (rd_pop && rd_valid) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(itff_pkg::QDepth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/itff_back.sv -----
// ----------------------------------------------------------------------------
// itff_back : result delivery
// Plays out the head request as a payload result, a status result, or
// a payload result followed by a status result.
// ----------------------------------------------------------------------------
`default_nettype none

module itff_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              q_valid,
  input  wire itff_pkg::itff_req_t               q_data,
  output logic                                   q_pop,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_kind,
  output logic [itff_pkg::ByteW-1:0]             out_payload_byte,
  output logic [itff_pkg::StatusW-1:0]           out_status,
  output logic [itff_pkg::ByteW-1:0]             out_ext_address,
  output logic [itff_pkg::LenW-1:0]              out_message_length,
  output logic [itff_pkg::CountW-1:0]            out_bytes_copied,
  output logic [itff_pkg::LenW-1:0]              out_bytes_remaining,
  output logic                                   out_last
);

  logic pl_sent_r, pl_sent_nxt;
  logic show_pl;
  logic out_fire;

  assign show_pl   = q_data.pl_valid && !pl_sent_r;
  assign out_valid = q_valid;
  assign out_fire  = out_valid && out_ready;

  always_comb begin
    out_kind            = 1'b1;
    out_payload_byte    = '0;
    out_status          = q_data.status;
    out_ext_address     = q_data.ext_address;
    out_message_length  = q_data.message_length;
    out_bytes_copied    = q_data.bytes_copied;
    out_bytes_remaining = q_data.bytes_remaining;
    out_last            = 1'b1;
    if (show_pl) begin
      out_kind            = 1'b0;
      out_payload_byte    = q_data.pl_byte;
      out_status          = itff_pkg::ST_OK;
      out_ext_address     = '0;
      out_message_length  = '0;
      out_bytes_copied    = '0;
      out_bytes_remaining = '0;
      out_last            = !q_data.st_valid;
    end
  end

  always_comb begin
    q_pop       = 1'b0;
    pl_sent_nxt = pl_sent_r;
    if (out_fire) begin
      if (show_pl && q_data.st_valid) begin
        pl_sent_nxt = 1'b1;
      end else begin
        q_pop       = 1'b1;
        pl_sent_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pl_sent_r <= 1'b0;
    end else begin
      pl_sent_r <= pl_sent_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/iso_tp_first_frame_parser.sv -----
// ----------------------------------------------------------------------------
// iso_tp_first_frame_parser : first-frame header decode and payload pass-out
// A byte's request is written to the queue when the byte is accepted and
// shows at the output from the queue head. One byte per cycle while the
// queue has room; payload goes out before status on the single result port.
// Reset (synchronous, rst_n low): frame state idle, queue empty, registers
// to ext_addr_present 0, fd_mode 0, buffer_size 4095.
// ----------------------------------------------------------------------------
`default_nettype none

module iso_tp_first_frame_parser (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration
  input  wire logic                              cfg_wr_en,
  input  wire logic [itff_pkg::CfgIdxW-1:0]      cfg_index,
  input  wire logic [itff_pkg::CfgW-1:0]         cfg_wdata,
  // frame bytes in
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [itff_pkg::ByteW-1:0]        in_frame_byte,
  input  wire logic                              in_frame_end,
  // results out
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_kind,
  output logic [itff_pkg::ByteW-1:0]             out_payload_byte,
  output logic [itff_pkg::StatusW-1:0]           out_status,
  output logic [itff_pkg::ByteW-1:0]             out_ext_address,
  output logic [itff_pkg::LenW-1:0]              out_message_length,
  output logic [itff_pkg::CountW-1:0]            out_bytes_copied,
  output logic [itff_pkg::LenW-1:0]              out_bytes_remaining,
  output logic                                   out_last
);

  // Front end decodes each byte into at most one request; the queue holds
  // requests so header decode keeps running during output stalls until full.
  logic                q_full;
  logic                q_wr_en;
  itff_pkg::itff_req_t q_wr_data;
  logic                q_valid;
  itff_pkg::itff_req_t q_rd_data;
  logic                q_pop;

  itff_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_frame_byte (in_frame_byte),
    .in_frame_end  (in_frame_end),
    .q_full        (q_full),
    .q_wr_en       (q_wr_en),
    .q_wr_data     (q_wr_data)
  );

  // two entries: a new byte is taken while the previous request drains
  itff_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_wr_en),
    .wr_data  (q_wr_data),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_data  (q_rd_data),
    .rd_pop   (q_pop)
  );

  // back end: payload result first, status result last
  itff_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_data              (q_rd_data),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_payload_byte    (out_payload_byte),
    .out_status          (out_status),
    .out_ext_address     (out_ext_address),
    .out_message_length  (out_message_length),
    .out_bytes_copied    (out_bytes_copied),
    .out_bytes_remaining (out_bytes_remaining),
    .out_last            (out_last)
  );

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb : self-checking bench for iso_tp_first_frame_parser
// Feeds first frames byte by byte (a directed table, then random frames under
// eight register settings) and checks every result against a cycle-free
// decode of the same bytes, held in a queue of pending results.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import itff_pkg::*;

  localparam int unsigned WD_LIMIT    = 1000;  // cycles with no request moved
  localparam int unsigned SETTLE_PAD  = 4;     // padding after the last result is checked
  localparam int unsigned PER_SETTING = 144;   // bytes per register setting
  localparam int unsigned NUM_SETTING = 8;

  // one result request, field for field as on the out_ ports
  typedef struct packed {
    logic               kind;
    logic [ByteW-1:0]   pb;
    logic [StatusW-1:0] st;
    logic [ByteW-1:0]   ea;
    logic [LenW-1:0]    ml;
    logic [CountW-1:0]  bc;
    logic [LenW-1:0]    br;
    logic               last;
  } res_t;

  // directed row: a byte, and where the result is obvious, its status by hand
  typedef struct packed {
    logic [ByteW-1:0]   data;
    logic               eof;
    logic               known;
    logic [StatusW-1:0] st;
    logic [LenW-1:0]    len;
  } row_t;

  typedef enum logic [2:0] {
    WAIT_START, WAIT_PCI, LEN_LOW, LEN_ESC, COPY, DROP
  } rx_phase_t;

  localparam int unsigned NUM_ROWS = 23;
  localparam row_t DIR_ROWS [NUM_ROWS] = '{
    // wrong frame type, rest of frame dropped
    '{8'h30, 1'b0, 1'b0, ST_OK,        32'd0},
    '{8'hff, 1'b1, 1'b1, ST_NOT_FF,    32'd0},
    '{8'h00, 1'b1, 1'b1, ST_NOT_FF,    32'd0},
    // ends inside the header
    '{8'h10, 1'b1, 1'b1, ST_TRUNC,     32'd0},
    // length 7, below the classic minimum
    '{8'h10, 1'b0, 1'b0, ST_OK,        32'd0},
    '{8'h07, 1'b1, 1'b1, ST_BELOW_MIN, 32'd7},
    // escaped length 4096, one past the reset buffer size
    '{8'h10, 1'b0, 1'b0, ST_OK,        32'd0},
    '{8'h00, 1'b0, 1'b0, ST_OK,        32'd0},
    '{8'h00, 1'b0, 1'b0, ST_OK,        32'd0},
    '{8'h00, 1'b0, 1'b0, ST_OK,        32'd0},
    '{8'h10, 1'b0, 1'b0, ST_OK,        32'd0},
    '{8'h00, 1'b1, 1'b1, ST_OVERFLOW,  32'd4096},
    // ends inside the escaped length
    '{8'h10, 1'b0, 1'b0, ST_OK,        32'd0},
    '{8'h00, 1'b0, 1'b0, ST_OK,        32'd0},
    '{8'h12, 1'b1, 1'b1, ST_TRUNC,     32'd0},
    // good classic frame, length 10, six bytes copied
    '{8'h10, 1'b0, 1'b0, ST_OK,        32'd0},
    '{8'h0a, 1'b0, 1'b0, ST_OK,        32'd0},
    '{8'h00, 1'b0, 1'b0, ST_OK,        32'd0},
    '{8'hff, 1'b0, 1'b0, ST_OK,        32'd0},
    '{8'h55, 1'b0, 1'b0, ST_OK,        32'd0},
    '{8'haa, 1'b0, 1'b0, ST_OK,        32'd0},
    '{8'h01, 1'b0, 1'b0, ST_OK,        32'd0},
    '{8'h80, 1'b1, 1'b0, ST_OK,        32'd0}
  };

  // register settings walked by the random part; extremes of buffer_size
  localparam logic             SET_EXT [NUM_SETTING] = '{1'b0, 1'b1, 1'b0, 1'b1,
                                                         1'b0, 1'b1, 1'b1, 1'b0};
  localparam logic             SET_FD  [NUM_SETTING] = '{1'b0, 1'b0, 1'b1, 1'b1,
                                                         1'b1, 1'b0, 1'b1, 1'b0};
  localparam logic [LenW-1:0]  SET_BUF [NUM_SETTING] = '{
    32'd4095, 32'hffff_ffff, 32'd0, 32'd100, 32'hffff_ffff, 32'd7, 32'd62,
    32'h8000_0000
  };
  localparam logic [CfgIdxW-1:0] CFG_ORDER [3] = '{CFG_EXT_ADDR, CFG_FD_MODE,
                                                   CFG_BUF_SIZE};
  localparam int unsigned FD_DLC [8] = '{8, 12, 16, 20, 24, 32, 48, 64};

  logic                clk;
  logic                rst_n         = 1'b0;
  logic                cfg_wr_en     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index     = CFG_EXT_ADDR;
  logic [CfgW-1:0]     cfg_wdata     = '0;
  logic                in_valid      = 1'b0;
  logic                in_ready;
  logic [ByteW-1:0]    in_frame_byte = '0;
  logic                in_frame_end  = 1'b0;
  logic                out_valid;
  logic                out_ready     = 1'b0;
  logic                out_kind;
  logic [ByteW-1:0]    out_payload_byte;
  logic [StatusW-1:0]  out_status;
  logic [ByteW-1:0]    out_ext_address;
  logic [LenW-1:0]     out_message_length;
  logic [CountW-1:0]   out_bytes_copied;
  logic [LenW-1:0]     out_bytes_remaining;
  logic                out_last;

  iso_tp_first_frame_parser dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_frame_byte       (in_frame_byte),
    .in_frame_end        (in_frame_end),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_payload_byte    (out_payload_byte),
    .out_status          (out_status),
    .out_ext_address     (out_ext_address),
    .out_message_length  (out_message_length),
    .out_bytes_copied    (out_bytes_copied),
    .out_bytes_remaining (out_bytes_remaining),
    .out_last            (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Decode model: register copies and per-frame state, as after reset
  // --------------------------------------------------------------------------
  logic              ext_on   = 1'b0;
  logic              fd_on    = 1'b0;
  logic [LenW-1:0]   buf_cap  = BUF_SIZE_RESET;
  rx_phase_t         ph       = WAIT_START;
  logic [2:0]        hdr_idx  = '0;
  logic [LenW-1:0]   len_acc  = '0;
  logic [ByteW-1:0]  ext_reg  = '0;
  logic [StatusW-1:0] err_code = ST_OK;
  logic [CountW-1:0] copy_cnt = '0;

  res_t        pending_results [$];
  int unsigned mismatches  = 0;
  int unsigned bytes_sent  = 0;
  int unsigned frames_sent = 0;
  int unsigned snd_idle    = 0;  // per cent of cycles the sender holds off
  int unsigned rcv_idle    = 0;  // per cent of cycles the receiver stalls

  function automatic logic [LenW-1:0] min_length();
    return (fd_on ? LenW'(MIN_LEN_FD) : LenW'(MIN_LEN_CAN)) - LenW'(ext_on);
  endfunction

  function automatic res_t status_res(input logic [StatusW-1:0] st,
                                      input logic [ByteW-1:0] ea,
                                      input logic [LenW-1:0] ml,
                                      input logic [CountW-1:0] bc,
                                      input logic [LenW-1:0] br);
    res_t r;
    r      = '0;
    r.kind = 1'b1;
    r.st   = st;
    r.ea   = ea;
    r.ml   = ml;
    r.bc   = bc;
    r.br   = br;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void raise_error(input logic [StatusW-1:0] code);
    err_code = code;
    ph       = DROP;
  endfunction

  function automatic void take_pci(input logic [ByteW-1:0] b);
    if ((b & PCI_TYPE_MASK) != PCI_TYPE_FF) begin
      raise_error(ST_NOT_FF);
    end else begin
      len_acc = LenW'(b & PCI_LEN_MASK) << 8;
      ph      = LEN_LOW;
    end
  endfunction

  // registers are read again here, not only at the frame's first byte
  function automatic void check_len();
    if (len_acc < min_length()) begin
      raise_error(ST_BELOW_MIN);
    end else if (len_acc > buf_cap) begin
      raise_error(ST_OVERFLOW);
    end else begin
      copy_cnt = '0;
      ph       = COPY;
    end
  endfunction

  // one accepted byte in, up to two results out (payload first, status last)
  task automatic decode_byte(input logic [ByteW-1:0] b, input logic eof,
                             output res_t r0, output res_t r1, output int n);
    res_t             outs [2];
    logic [LenW-1:0]  ml;
    n       = 0;
    outs[0] = '0;
    outs[1] = '0;
    case (ph)
      WAIT_START: begin
        ext_reg = '0;
        if ({1'b0, buf_cap} > {1'b0, MAX_MESSAGE_LEN}) begin
          raise_error(ST_BAD_SIZE);
        end else if (ext_on) begin
          ext_reg = b;
          ph      = WAIT_PCI;
        end else begin
          take_pci(b);
        end
      end
      WAIT_PCI: take_pci(b);
      LEN_LOW: begin
        len_acc = len_acc | LenW'(b);
        if (len_acc == '0) begin
          // zero 12-bit length: a 32-bit length follows, MSB first
          hdr_idx = '0;
          ph      = LEN_ESC;
        end else begin
          check_len();
        end
      end
      LEN_ESC: begin
        len_acc = {len_acc[LenW-9:0], b};
        hdr_idx = hdr_idx + 3'd1;
        if (hdr_idx >= 3'd4) check_len();
      end
      COPY: begin
        // stops at the message length or 64 bytes, whichever first
        if (LenW'(copy_cnt) < len_acc && copy_cnt < MAX_COPY) begin
          outs[n]      = '0;
          outs[n].pb   = b;
          outs[n].last = !eof;
          n++;
          copy_cnt++;
        end
      end
      default: ;
    endcase
    if (eof) begin
      if (ph == COPY) begin
        outs[n] = status_res(ST_OK, ext_reg, len_acc, copy_cnt,
                             len_acc - LenW'(copy_cnt));
      end else if (ph == DROP) begin
        ml = (err_code == ST_BELOW_MIN || err_code == ST_OVERFLOW) ? len_acc : '0;
        outs[n] = status_res(err_code, ext_reg, ml, '0, '0);
      end else begin
        outs[n] = status_res(ST_TRUNC, ext_reg, '0, '0, '0);
      end
      n++;
      ph       = WAIT_START;
      hdr_idx  = '0;
      len_acc  = '0;
      ext_reg  = '0;
      err_code = ST_OK;
      copy_cnt = '0;
    end
    r0 = outs[0];
    r1 = outs[1];
  endtask

  // --------------------------------------------------------------------------
  // Sender side. Every task starts and ends on a rising edge; in_valid gets
  // at most one nonblocking write per step.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [ByteW-1:0] b, input logic eof,
                           input logic known, input res_t known_res);
    res_t r0;
    res_t r1;
    int   n;
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle);
    end
    in_valid      <= 1'b1;
    in_frame_byte <= b;
    in_frame_end  <= eof;
    do @(posedge clk); while (!in_ready);
    // request taken at this edge; its results cannot show before the next
    decode_byte(b, eof, r0, r1, n);
    if (known) begin
      pending_results.push_back(known_res);
    end else begin
      if (n > 0) pending_results.push_back(r0);
      if (n > 1) pending_results.push_back(r1);
    end
    bytes_sent++;
  endtask

  // stop sending and let the block run dry
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_PAD) @(posedge clk);
  endtask

  // writes all three registers, one per cycle, with the block idle
  task automatic apply_setting(input int unsigned s);
    logic [CfgW-1:0] word;
    for (int i = 0; i < 3; i++) begin
      word = $urandom;
      case (CFG_ORDER[i])
        CFG_EXT_ADDR: word[0] = SET_EXT[s];
        CFG_FD_MODE:  word[0] = SET_FD[s];
        default:      word    = SET_BUF[s];
      endcase
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_ORDER[i];
      cfg_wdata <= word;
      @(posedge clk);
      // single-bit registers keep bit 0 only
      case (CFG_ORDER[i])
        CFG_EXT_ADDR: ext_on  = word[0];
        CFG_FD_MODE:  fd_on   = word[0];
        default:      buf_cap = word;
      endcase
    end
    cfg_wr_en <= 1'b0;
  endtask

  // mostly well-formed first frames with random content; some noise, some
  // corrupt type nibbles, some frames cut short or run past 64 bytes
  task automatic random_frame();
    logic [ByteW-1:0] fb [$];
    logic [LenW-1:0]  len;
    int unsigned      pick;
    int unsigned      total;
    pick = $urandom_range(99);
    if (pick < 12) begin
      total = $urandom_range(1, 12);
      repeat (total) fb.push_back($urandom);
    end else begin
      if (ext_on) fb.push_back($urandom);
      case ($urandom_range(9))
        0:       len = min_length() - 1;
        1:       len = min_length();
        2:       len = buf_cap;
        3:       len = buf_cap + 1;
        4:       len = $urandom;
        5:       len = $urandom_range(1, 4095);
        default: len = min_length() + $urandom_range(0, 80);
      endcase
      if (len != '0 && len < 4096 && $urandom_range(3) != 0) begin
        fb.push_back(PCI_TYPE_FF | ByteW'(len[11:8]));
        fb.push_back(len[7:0]);
      end else begin
        fb.push_back(PCI_TYPE_FF);
        fb.push_back(8'h00);
        for (int k = 3; k >= 0; k--) fb.push_back(len[8*k +: 8]);
      end
      if (pick < 20) fb[ext_on ? 1 : 0] = $urandom;
      if ($urandom_range(7) == 0) total = $urandom_range(1, 80);
      else if (fd_on)             total = FD_DLC[$urandom_range(7)];
      else                        total = 8;
      while (fb.size() < total) fb.push_back($urandom);
      while (fb.size() > total) void'(fb.pop_back());
    end
    foreach (fb[i]) send_byte(fb[i], i == fb.size() - 1, 1'b0, '0);
    frames_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: random stalls, then checking of each request taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle);
  end

  task automatic report_mismatch(input string what, input logic [LenW-1:0] got,
                                 input logic [LenW-1:0] want);
    mismatches++;
    $display("%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, kind", LenW'(out_kind), '0);
      end else begin
        want = pending_results.pop_front();
        if (out_kind !== want.kind)
          report_mismatch("kind", LenW'(out_kind), LenW'(want.kind));
        if (out_payload_byte !== want.pb)
          report_mismatch("payload_byte", LenW'(out_payload_byte), LenW'(want.pb));
        if (out_status !== want.st)
          report_mismatch("status", LenW'(out_status), LenW'(want.st));
        if (out_ext_address !== want.ea)
          report_mismatch("ext_address", LenW'(out_ext_address), LenW'(want.ea));
        if (out_message_length !== want.ml)
          report_mismatch("message_length", out_message_length, want.ml);
        if (out_bytes_copied !== want.bc)
          report_mismatch("bytes_copied", LenW'(out_bytes_copied), LenW'(want.bc));
        if (out_bytes_remaining !== want.br)
          report_mismatch("bytes_remaining", out_bytes_remaining, want.br);
        if (out_last !== want.last)
          report_mismatch("last", LenW'(out_last), LenW'(want.last));
      end
    end
  end

  // watchdog: too long without any request moving on either side
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WD_LIMIT) begin
      $display("iso_tp_first_frame_parser verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Run: reset, directed table under reset registers, then random frames
  // under each setting. Idling: sender light / receiver heavy, then the
  // reverse, then none.
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    for (int unsigned s = 0; s < NUM_SETTING; s++) begin
      if (s < 3) begin
        snd_idle = 23;
        rcv_idle = 73;
      end else if (s < 6) begin
        snd_idle = 73;
        rcv_idle = 23;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      if (s == 0) begin
        foreach (DIR_ROWS[i])
          send_byte(DIR_ROWS[i].data, DIR_ROWS[i].eof, DIR_ROWS[i].known,
                    status_res(DIR_ROWS[i].st, '0, DIR_ROWS[i].len, '0, '0));
      end else begin
        drain();
        apply_setting(s);
      end
      while (bytes_sent < (s + 1) * PER_SETTING) begin
        random_frame();
        // now and then the sender waits for the block to empty
        if (frames_sent % 25 == 0) drain();
      end
    end
    drain();
    if (mismatches == 0) begin
      $display("iso_tp_first_frame_parser verification clean");
    end else begin
      $display("iso_tp_first_frame_parser verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
hw/rtl/itff_pkg.sv
hw/rtl/itff_front.sv
hw/rtl/itff_queue.sv
hw/rtl/itff_back.sv
hw/rtl/iso_tp_first_frame_parser.sv
test/tb.sv
